// ----- rtl/bcf_pkg.sv -----
package bcf_pkg;

  localparam int STEP_W = 6;
  localparam int T_W = 17;
  localparam int W_W = 49;
  localparam int DCNT_W = 5;
  localparam int MAX_STEPS_DEF = 63;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [STEP_W-1:0] DEF_STEPS = 6'd16;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam logic REG_STEPS = 1'b0;

  typedef struct packed {
    logic           last;
    logic [T_W-1:0] t;
  } pt_ctl_t;

endpackage

// ----- rtl/bcf_eval.sv -----
module bcf_eval #(
  parameter int COORD_BITS = bcf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue_valid,
  input  bcf_pkg::pt_ctl_t             issue_ctl,
  input  logic [3:0][COORD_BITS-1:0]   ax,
  input  logic [3:0][COORD_BITS-1:0]   ay,
  output logic                         adv,
  output logic                         pt_valid,
  input  logic                         pt_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         last_point
);
  import bcf_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = CW + 26;
  localparam int SW = PW + 2;
  localparam int TW = SW + 25;

  logic v1, v2, v3, v4, v5;
  logic l1, l2, l3, l4, l5;
  logic [T_W-1:0] t1, u1;
  logic [2*T_W-1:0] uu1, tt1;
  logic [W_W-1:0] w0_2, p1_2, p2_2, w3_2;
  logic [W_W-1:0] w3 [4];
  logic [CW-1:0] ax1 [4], ax2 [4], ax3 [4];
  logic [CW-1:0] ay1 [4], ay2 [4], ay3 [4];
  logic signed [PW-1:0] phx [4], plx [4], phy [4], ply [4];
  logic signed [SW-1:0] shx, slx, shy, sly;
  logic [T_W-1:0] u_in;
  logic signed [CW-1:0] rx, ry;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] sh,
                                                     input logic signed [SW-1:0] sl);
    logic signed [TW-1:0] tot;
    logic signed [TW-1:0] r;
    logic signed [CW-1:0] res;
    tot = (TW'(sh) <<< 24) + TW'(sl) + (TW'(1) <<< 47);
    r = tot >>> 48;
    if (&r[TW-1:CW-1] || ~|r[TW-1:CW-1]) begin
      res = r[CW-1:0];
    end else if (r[TW-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

  assign adv = !pt_valid || pt_ready;
  assign u_in = T_ONE - issue_ctl.t;
  assign rx = round_sat(shx, slx);
  assign ry = round_sat(shy, sly);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      v1 <= issue_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      pt_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: squares
      t1 <= issue_ctl.t;
      u1 <= u_in;
      uu1 <= (2*T_W)'(u_in) * (2*T_W)'(u_in);
      tt1 <= (2*T_W)'(issue_ctl.t) * (2*T_W)'(issue_ctl.t);
      l1 <= issue_ctl.last;
      // stage 2: cubes
      w0_2 <= W_W'(51'(uu1) * 51'(u1));
      p1_2 <= W_W'(51'(uu1) * 51'(t1));
      p2_2 <= W_W'(51'(tt1) * 51'(u1));
      w3_2 <= W_W'(51'(tt1) * 51'(t1));
      l2 <= l1;
      // stage 3: bernstein weights
      w3[0] <= w0_2;
      w3[1] <= p1_2 + (p1_2 << 1);
      w3[2] <= p2_2 + (p2_2 << 1);
      w3[3] <= w3_2;
      l3 <= l2;
      // stage 5: partial sums
      shx <= SW'(phx[0]) + SW'(phx[1]) + SW'(phx[2]) + SW'(phx[3]);
      slx <= SW'(plx[0]) + SW'(plx[1]) + SW'(plx[2]) + SW'(plx[3]);
      shy <= SW'(phy[0]) + SW'(phy[1]) + SW'(phy[2]) + SW'(phy[3]);
      sly <= SW'(ply[0]) + SW'(ply[1]) + SW'(ply[2]) + SW'(ply[3]);
      l5 <= l4;
      // stage 6: round, saturate
      point_x <= rx;
      point_y <= ry;
      last_point <= l5;
      l4 <= l3;
      for (int i = 0; i < 4; i++) begin
        ax1[i] <= ax[i];
        ay1[i] <= ay[i];
        ax2[i] <= ax1[i];
        ay2[i] <= ay1[i];
        ax3[i] <= ax2[i];
        ay3[i] <= ay2[i];
        // stage 4: coordinate times weight halves
        phx[i] <= PW'($signed(ax3[i])) * PW'($signed({1'b0, w3[i][48:24]}));
        plx[i] <= PW'($signed(ax3[i])) * PW'($signed({2'b0, w3[i][23:0]}));
        phy[i] <= PW'($signed(ay3[i])) * PW'($signed({1'b0, w3[i][48:24]}));
        ply[i] <= PW'($signed(ay3[i])) * PW'($signed({2'b0, w3[i][23:0]}));
      end
    end
  end

endmodule

// ----- rtl/cubic_bezier_flattener.sv -----
// cubic bezier flattener, uniform steps
// seg channel (seg_valid/seg_ready) takes one segment per beat: start,
// two control points, end (signed q12.4) and first_segment.
// pt channel (pt_valid/pt_ready) returns points at t = k/steps, the
// t = 1 point flagged by last_point; a chained segment skips k = 0.
// bezier_steps lives at apb address 0; a written 0 acts as 1 step.
// after reset and after every bezier_steps write a bit-serial divider
// forms 65536/steps, with seg_ready low meanwhile. a segment then
// issues one point per cycle, while pt does not stall, from a step
// sequencer into a six-stage evaluator; the next segment is taken
// once the sequencer has issued its t = 1 point. the first point
// reaches pt through the sequencer registers and every evaluator stage.
// when pt_valid is high and pt_ready low the whole evaluator and the
// sequencer hold; nothing is dropped or repeated. reset empties the
// pipeline and sets bezier_steps to 16.
module cubic_bezier_flattener #(
  parameter int MAX_STEPS  = bcf_pkg::MAX_STEPS_DEF,
  parameter int COORD_BITS = bcf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         seg_valid,
  output logic                         seg_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] ctrl1_x,
  input  logic signed [COORD_BITS-1:0] ctrl1_y,
  input  logic signed [COORD_BITS-1:0] ctrl2_x,
  input  logic signed [COORD_BITS-1:0] ctrl2_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         first_segment,
  output logic                         pt_valid,
  input  logic                         pt_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         last_point
);
  import bcf_pkg::*;

  localparam int CW = COORD_BITS;

  logic [STEP_W-1:0] bezier_steps;
  logic              cfg_wr;
  logic              div_run;
  logic [DCNT_W-1:0] div_cnt;
  logic [STEP_W:0]   div_rem;
  logic [T_W-1:0]    div_q;
  logic [STEP_W-1:0] div_s;
  logic [STEP_W:0]   rem_sh;
  logic              q_bit;

  logic              busy;
  logic [STEP_W-1:0] k;
  logic [T_W-1:0]    t;
  logic [STEP_W-1:0] rem;
  logic [STEP_W:0]   rem_sum;
  logic [T_W-1:0]    t_next;
  logic [STEP_W-1:0] rem_next;
  logic [3:0][CW-1:0] ax, ay;
  logic              adv;
  logic              seg_acc;
  logic              k_last;
  pt_ctl_t           issue_ctl;

  function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] s);
    logic [STEP_W-1:0] r;
    if (s == '0) begin
      r = STEP_W'(1);
    end else if (s > STEP_W'(MAX_STEPS)) begin
      r = STEP_W'(MAX_STEPS);
    end else begin
      r = s;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign prdata = {{(32-STEP_W){1'b0}}, bezier_steps};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STEPS);

  // restoring divide of 65536 by steps, one quotient bit a cycle
  assign rem_sh = {div_rem[STEP_W-1:0], (div_cnt == DCNT_W'(T_W-1))};
  assign q_bit = (rem_sh >= {1'b0, div_s});

  always_ff @(posedge clk) begin
    if (rst) begin
      bezier_steps <= DEF_STEPS;
      div_run <= 1'b1;
      div_cnt <= DCNT_W'(T_W-1);
      div_rem <= '0;
      div_q <= '0;
      div_s <= clamp_steps(DEF_STEPS);
    end else if (cfg_wr) begin
      bezier_steps <= pwdata[STEP_W-1:0];
      div_run <= 1'b1;
      div_cnt <= DCNT_W'(T_W-1);
      div_rem <= '0;
      div_q <= '0;
      div_s <= clamp_steps(pwdata[STEP_W-1:0]);
    end else if (div_run) begin
      div_rem <= q_bit ? rem_sh - {1'b0, div_s} : rem_sh;
      div_q <= {div_q[T_W-2:0], q_bit};
      div_cnt <= div_cnt - DCNT_W'(1);
      if (div_cnt == '0) begin
        div_run <= 1'b0;
      end
    end
  end

  // step sequencer: t advances by 65536/steps with a carried remainder
  assign seg_ready = !busy && !div_run;
  assign seg_acc = seg_valid && seg_ready;
  assign k_last = (k == div_s);
  assign rem_sum = {1'b0, rem} + {1'b0, div_rem[STEP_W-1:0]};
  always_comb begin
    if (rem_sum >= {1'b0, div_s}) begin
      rem_next = STEP_W'(rem_sum - {1'b0, div_s});
      t_next = t + div_q + T_W'(1);
    end else begin
      rem_next = rem_sum[STEP_W-1:0];
      t_next = t + div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (seg_acc) begin
      busy <= 1'b1;
    end else if (busy && adv && k_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_acc) begin
      ax <= {end_x, ctrl2_x, ctrl1_x, start_x};
      ay <= {end_y, ctrl2_y, ctrl1_y, start_y};
      if (first_segment) begin
        k <= '0;
        t <= '0;
        rem <= '0;
      end else begin
        k <= STEP_W'(1);
        t <= div_q;
        rem <= div_rem[STEP_W-1:0];
      end
    end else if (busy && adv && !k_last) begin
      k <= k + STEP_W'(1);
      t <= t_next;
      rem <= rem_next;
    end
  end

  assign issue_ctl.last = k_last;
  assign issue_ctl.t = t;

  bcf_eval #(
    .COORD_BITS(COORD_BITS)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .issue_valid(busy),
    .issue_ctl  (issue_ctl),
    .ax         (ax),
    .ay         (ay),
    .adv        (adv),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

`ifndef ASSERT_OFF
  a_last_t_one: assert property (@(posedge clk) disable iff (rst)
    busy && k_last |-> t == T_ONE)
    else $error("last step does not land on t = 1");

  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    !div_run |-> (24'(div_q) * 24'(div_s) + 24'(div_rem)) == 24'(T_ONE))
    else $error("step quotient and remainder inconsistent");

  a_seg_busy: assert property (@(posedge clk) disable iff (rst)
    seg_acc |=> busy && !seg_ready)
    else $error("segment beat did not start the sequencer");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < div_s)
    else $error("step remainder out of range");
`endif

endmodule
